// ===== design/deq_pkg.sv =====
// Shared constants and types for the double-ended queue.
`default_nettype none
package deq_pkg;

    // Ring store geometry.
    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 11;

    // Command codes carried by each input item.
    typedef enum logic [2:0] {
        CMD_ADD_FRONT  = 3'd0,
        CMD_ADD_BACK   = 3'd1,
        CMD_TAKE_FRONT = 3'd2,
        CMD_TAKE_BACK  = 3'd3,
        CMD_SIZE       = 3'd4,
        CMD_EMPTY      = 3'd5,
        CMD_PEEK_FRONT = 3'd6,
        CMD_PEEK_BACK  = 3'd7
    } t_cmd;

    // Status codes carried by each result item.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage
`default_nettype wire

// ===== design/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words held in a single-port-write ring memory.
//
// Usage:
//   The input channel (i_in_valid / o_in_ready) carries a command and a data
//   word. Pushes place the word at the front or back; pops remove and report
//   the word at one end; peeks report it without removing it; size and empty
//   report occupancy. A successful push gives no result item; every other
//   command, including a push into a full queue (dropped, status full) and a
//   pop or peek on an empty queue (status empty), gives exactly one item on
//   the output channel (o_out_valid / i_out_ready).
//   Each result item waits in the read stage for the memory's registered read
//   port, then moves to the output register. Throughput: one item per cycle
//   unless the receiver stalls. Pointers and count update at the accept
//   edge, so the next command sees them at once; the memory is written and
//   read at accept edges only, so a read always sees the previous write.
//   When the receiver stalls, the output register and the read stage hold
//   their items and o_in_ready drops once both are full.
//   Reset (synchronous, active low) empties the queue at once; the ring
//   memory itself is not cleared, as no entry is read before it is written.
`default_nettype none
module double_ended_queue (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire deq_pkg::t_cmd                i_command,
    input  wire logic signed [31:0]           i_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output deq_pkg::t_status                  o_status,
    output logic signed [31:0]                o_value,
    output logic [deq_pkg::COUNT_W-1:0]       o_count,
    output logic                              o_is_empty
);
    import deq_pkg::*;

    // Ring memory and its registered read data.
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // Queue pointers.
    logic [ADDR_W-1:0] r_front, n_front;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // Read stage: result metadata waiting for memory data.
    logic              r_s1_valid, n_s1_valid;
    t_status           r_s1_status, n_s1_status;
    logic              r_s1_use_mem, n_s1_use_mem;
    logic [CNT_W-1:0]  r_s1_cnt;

    logic              in_acc;
    logic              s1_move;
    logic              full;
    logic              empty;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] front_dec;
    logic [ADDR_W-1:0] front_inc;
    logic [ADDR_W-1:0] back_pos;
    logic [CNT_W-1:0]  offset;
    logic [ADDR_W+1:0] pos_sum;

    // Handshake between the stages.
    assign s1_move    = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;

    assign full  = (r_cnt == CNT_W'(DEPTH));
    assign empty = (r_cnt == '0);

    // Ring positions next to the front and at the back.
    assign front_dec = (r_front == '0) ? ADDR_W'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == ADDR_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign offset    = (i_command == CMD_ADD_BACK) ? r_cnt : r_cnt - 1'b1;
    assign pos_sum   = (ADDR_W + 2)'(r_front) + (ADDR_W + 2)'(offset);
    assign back_pos  = (pos_sum >= (ADDR_W + 2)'(DEPTH))
                     ? ADDR_W'(pos_sum - (ADDR_W + 2)'(DEPTH))
                     : ADDR_W'(pos_sum);

    // Command decode: next pointers, memory access and result metadata.
    always_comb begin
        n_front      = r_front;
        n_cnt        = r_cnt;
        n_s1_status  = ST_OK;
        n_s1_use_mem = 1'b0;
        n_s1_valid   = 1'b1;
        wr_en        = 1'b0;
        wr_addr      = back_pos;
        rd_addr      = r_front;
        case (i_command)
            CMD_ADD_FRONT: begin
                if (full) begin
                    n_s1_status = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = front_dec;
                    n_front    = front_dec;
                    n_cnt      = r_cnt + 1'b1;
                    n_s1_valid = 1'b0;
                end
            end
            CMD_ADD_BACK: begin
                if (full) begin
                    n_s1_status = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    n_s1_valid = 1'b0;
                end
            end
            CMD_TAKE_FRONT: begin
                if (empty) begin
                    n_s1_status = ST_EMPTY;
                end else begin
                    n_s1_use_mem = 1'b1;
                    n_front      = front_inc;
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            CMD_TAKE_BACK: begin
                rd_addr = back_pos;
                if (empty) begin
                    n_s1_status = ST_EMPTY;
                end else begin
                    n_s1_use_mem = 1'b1;
                    n_cnt        = r_cnt - 1'b1;
                end
            end
            CMD_PEEK_FRONT: begin
                if (empty) n_s1_status = ST_EMPTY;
                else       n_s1_use_mem = 1'b1;
            end
            CMD_PEEK_BACK: begin
                rd_addr = back_pos;
                if (empty) n_s1_status = ST_EMPTY;
                else       n_s1_use_mem = 1'b1;
            end
            default: begin
                // Size and empty queries only report occupancy.
                n_s1_status = ST_OK;
            end
        endcase
    end

    // Memory write and registered read, both on accepted items only.
    always_ff @(posedge i_clk) begin
        if (in_acc && wr_en) begin
            r_mem[wr_addr] <= i_data;
        end
        if (in_acc) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Pointers and read-stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_front    <= n_front;
            r_cnt      <= n_cnt;
            r_s1_valid <= n_s1_valid;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Read-stage payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_status  <= n_s1_status;
            r_s1_use_mem <= n_s1_use_mem;
            r_s1_cnt     <= n_cnt;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_move) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            o_status   <= r_s1_status;
            o_value    <= r_s1_use_mem ? r_rdata : '0;
            o_count    <= COUNT_W'(r_s1_cnt);
            o_is_empty <= (r_s1_cnt == '0);
        end
    end

    // The count never exceeds the ring size.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("entry count beyond ring size");

    // A push into a full queue leaves the occupancy unchanged.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && full && (i_command == CMD_ADD_FRONT || i_command == CMD_ADD_BACK)
        |=> $stable(r_cnt) && $stable(r_front))
        else $error("push into full queue changed state");

    // Only successful reads report a non-zero value.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_value == '0)
        else $error("failed command reported a value");

    // A held read stage must not lose its item to a new command.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |-> !in_acc)
        else $error("command accepted over a stalled read stage");

endmodule
`default_nettype wire
